// ----- rtl/core/sha512_pkg.sv -----
// Package: SHA-512 round constants, initial hash and helper functions.
`default_nettype none
package sha512_pkg;

    localparam int WordWidth  = 64;
    localparam int BlockWords = 16;
    localparam int Rounds     = 80;
    localparam int DigestWords = 8;

    typedef logic [WordWidth-1:0] word_t;

    function automatic word_t round_k(input logic [6:0] idx);
        word_t k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t initial_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 64'h6a09e667f3bcc908;
            3'd1: h = 64'hbb67ae8584caa73b;
            3'd2: h = 64'h3c6ef372fe94f82b;
            3'd3: h = 64'ha54ff53a5f1d36f1;
            3'd4: h = 64'h510e527fade682d1;
            3'd5: h = 64'h9b05688c2b3e6c1f;
            3'd6: h = 64'h1f83d9abfb41bd6b;
            3'd7: h = 64'h5be0cd19137e2179;
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sha512_hash_engine.sv -----
// Top level: SHA-512 engine with padding, one compression round per cycle.
//
//  channel   signals                                         direction
//  in        in_valid, in_stall, message_word, valid_bytes,  request in
//            end_of_message
//  out       out_valid, out_stall, digest_word, word_index,  result out
//            last_word
//
// A non-last word is simply taken, unless it fills a block: then the accept is
// followed by 80 rounds on the one shared round unit and a fold into the hash state.
// A last word is followed by one padding or length word per cycle up to the end
// of the block, with the rounds and the fold run for each block that fills, then
// the block shows eight digest words, one per unstalled cycle.
// in_stall is high whenever the block is not idle. Reset loads the initial
// hash and clears the counters; the block buffer is left as it is.
`default_nettype none
module sha512_hash_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    typedef logic [63:0] w_t;

    state_t state_reg, state_next;
    w_t     hash_reg [8];
    w_t     sched_reg [16];
    w_t     var_reg [8];
    logic [3:0]   pos_reg;
    logic [127:0] count_reg;
    logic [6:0]   round_reg;
    logic         finish_reg;   // padding in progress
    logic [1:0]   pad_step_reg; // 0: data word, 1: zero fill, 2: len hi, 3: len lo
    logic         pad_done_reg;
    w_t           data_reg;     // first padded word
    logic [2:0]   out_idx_reg;

    // push source
    logic push;
    w_t   push_word;

    // round datapath
    logic [3:0] r;
    w_t s0, s1, w_new, w_cur, t1, t2;
    always_comb
    begin
        r     = round_reg[3:0];
        s1    = sha512_pkg::rotr(sched_reg[r + 4'd14], 19)
              ^ sha512_pkg::rotr(sched_reg[r + 4'd14], 61) ^ (sched_reg[r + 4'd14] >> 6);
        s0    = sha512_pkg::rotr(sched_reg[r + 4'd1], 1)
              ^ sha512_pkg::rotr(sched_reg[r + 4'd1], 8) ^ (sched_reg[r + 4'd1] >> 7);
        w_new = s1 + sched_reg[r + 4'd9] + s0 + sched_reg[r];
        w_cur = (round_reg >= 7'd16) ? w_new : sched_reg[r];
        t1 = var_reg[7]
           + (sha512_pkg::rotr(var_reg[4], 14) ^ sha512_pkg::rotr(var_reg[4], 18)
              ^ sha512_pkg::rotr(var_reg[4], 41))
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + sha512_pkg::round_k(round_reg) + w_cur;
        t2 = (sha512_pkg::rotr(var_reg[0], 28) ^ sha512_pkg::rotr(var_reg[0], 34)
              ^ sha512_pkg::rotr(var_reg[0], 39))
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));
    end

    logic       accept;
    logic [3:0] nbytes;
    logic [6:0] shamt;
    w_t         keep, padded;
    always_comb
    begin
        accept = in_valid && !in_stall;
        nbytes = (!end_of_message || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        shamt  = 7'd64 - {nbytes[3:0], 3'b000};
        keep   = (nbytes == 4'd0) ? '0 : ({64{1'b1}} << shamt);
        padded = (message_word & keep) | (64'h80 << (7'd56 - {nbytes, 3'b000}));
    end

    // word to push: the accepted message word, or the padding word for the current pad step
    always_comb
    begin
        push      = 1'b0;
        push_word = message_word;
        if (state_reg == ST_IDLE && accept)
        begin
            push      = !end_of_message || nbytes == 4'd8;
            push_word = message_word;
        end
        else if (state_reg == ST_PAD)
        begin
            push = 1'b1;
            case (pad_step_reg)
                2'd0: push_word = data_reg;
                2'd1: push_word = '0;
                2'd2: push_word = count_reg[127:64];
                default: push_word = count_reg[63:0];
            endcase
        end
    end

    logic [1:0] pad_step_next;
    logic       pad_done;
    always_comb
    begin
        pad_step_next = pad_step_reg;
        pad_done      = 1'b0;
        case (pad_step_reg)
            2'd0: pad_step_next = (pos_reg == 4'd13) ? 2'd2 : 2'd1;
            2'd1: pad_step_next = (pos_reg == 4'd13) ? 2'd2 : 2'd1;
            2'd2: pad_step_next = 2'd3;
            default: pad_done = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    // a full word in the final slot closes the block first, also when it is the last word
                    if (push && pos_reg == 4'd15)
                        state_next = ST_ROUND;
                    else if (end_of_message)
                        state_next = ST_PAD;
                end
            ST_PAD:
                if (pos_reg == 4'd15)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (round_reg == 7'(sha512_pkg::Rounds - 1))
                    state_next = ST_FOLD;
            ST_FOLD:
                state_next = finish_reg ? (pad_done_reg ? ST_OUT : ST_PAD) : ST_IDLE;
            ST_OUT:
                if (!out_stall && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            count_reg    <= '0;
            round_reg    <= '0;
            finish_reg   <= 1'b0;
            pad_step_reg <= '0;
            pad_done_reg <= 1'b0;
            out_idx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= sha512_pkg::initial_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                sched_reg[pos_reg] <= push_word;
                pos_reg <= pos_reg + 4'd1;
                if (pos_reg == 4'd15)
                    for (int i = 0; i < 8; i++)
                        var_reg[i] <= hash_reg[i];
            end
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        count_reg <= count_reg + {121'd0, nbytes, 3'b000};
                        if (end_of_message)
                        begin
                            finish_reg   <= 1'b1;
                            pad_done_reg <= 1'b0;
                            data_reg     <= (nbytes == 4'd8) ? 64'h8000000000000000 : padded;
                            pad_step_reg <= 2'd0;
                        end
                    end
                ST_PAD:
                begin
                    pad_step_reg <= pad_step_next;
                    if (pad_done)
                        pad_done_reg <= 1'b1;
                end
                ST_ROUND:
                begin
                    if (round_reg >= 7'd16)
                        sched_reg[r] <= w_new;
                    var_reg[7] <= var_reg[6]; var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4]; var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2]; var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0]; var_reg[0] <= t1 + t2;
                    round_reg <= (round_reg == 7'(sha512_pkg::Rounds - 1)) ? '0
                               : round_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + var_reg[i];
                    out_idx_reg <= '0;
                end
                ST_OUT:
                    if (!out_stall)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            finish_reg <= 1'b0;
                            count_reg  <= '0;
                            pos_reg    <= '0;
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= sha512_pkg::initial_hash(3'(i));
                        end
                    end
                default: ;
            endcase
        end
    end

    assign in_stall    = state_reg != ST_IDLE;
    assign out_valid   = state_reg == ST_OUT;
    assign digest_word = hash_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = out_idx_reg == 3'd7;

endmodule
`default_nettype wire

// ----- rtl/core/sha512_checker.sv -----
// Checker: port-level properties of the SHA-512 engine, bound to the top.
`default_nettype none
module sha512_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while results pending");
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_word |=> out_valid &&
        word_index == $past(word_index) + 3'd1)
        else $error("digest words out of order");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word))
        else $error("stalled result changed");
endmodule

bind sha512_hash_engine sha512_checker u_sha512_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
);
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for the SHA-512 hash engine: padded messages checked against a local digest model.
`timescale 1ns / 100ps
`default_nettype none

class digest_scoreboard;
    logic [63:0] hash_acc [8];
    logic [63:0] blk [16];
    int unsigned fill;
    logic [127:0] bit_count;
    logic [63:0] want_word [$];
    logic [2:0] want_index [$];
    logic want_last [$];
    int unsigned mismatches;
    int unsigned digests_seen;
    int unsigned words_seen;

    static function logic [63:0] rotr64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    static function logic [63:0] k_const(int r);
        logic [63:0] k [80];
        k = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
            64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
            64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
            64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
            64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
            64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
            64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
            64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
            64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
            64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
            64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
            64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
            64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
            64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
            64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
            64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
            64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
            64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
            64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
            64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
            64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
        return k[r];
    endfunction

    function void restart();
        hash_acc = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
                     64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
                     64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                     64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        fill = 0;
        bit_count = '0;
    endfunction

    function new();
        restart();
        mismatches = 0;
        digests_seen = 0;
        words_seen = 0;
    endfunction

    function void compress();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] s0, s1, t1, t2;
        int r, j;
        w = blk;
        v = hash_acc;
        for (r = 0; r < 80; r++)
        begin
            j = r % 16;
            if (r >= 16)
            begin
                s1 = rotr64(w[(j + 14) % 16], 19) ^ rotr64(w[(j + 14) % 16], 61)
                     ^ (w[(j + 14) % 16] >> 6);
                s0 = rotr64(w[(j + 1) % 16], 1) ^ rotr64(w[(j + 1) % 16], 8)
                     ^ (w[(j + 1) % 16] >> 7);
                w[j] = s1 + w[(j + 9) % 16] + s0 + w[j];
            end
            t1 = v[7] + (rotr64(v[4], 14) ^ rotr64(v[4], 18) ^ rotr64(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + w[j];
            t2 = (rotr64(v[0], 28) ^ rotr64(v[0], 34) ^ rotr64(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++)
            hash_acc[j] += v[j];
    endfunction

    function void push(logic [63:0] w);
        blk[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0)
            compress();
    endfunction

    // note an accepted request and queue the digest it completes, if any
    function void note_request(logic [63:0] word, logic [3:0] nb_in, logic eom);
        int nb;
        logic [63:0] keep;
        nb = (!eom || nb_in > 8) ? 8 : nb_in;
        bit_count += 128'(nb * 8);
        if (!eom)
        begin
            push(word);
            return;
        end
        if (nb == 8)
        begin
            push(word);
            push(64'h8000000000000000);
        end
        else
        begin
            keep = (nb == 0) ? 64'h0 : ~64'h0 << (64 - 8 * nb);
            push((word & keep) | (64'h80 << (56 - 8 * nb)));
        end
        if (fill == 15)
            push(64'h0);
        while (fill < 14)
            push(64'h0);
        push(bit_count[127:64]);
        push(bit_count[63:0]);
        for (int i = 0; i < 8; i++)
        begin
            want_word.push_back(hash_acc[i]);
            want_index.push_back(3'(i));
            want_last.push_back(i == 7);
        end
        digests_seen++;
        restart();
    endfunction

    function void check_digest_word(logic [63:0] dw, logic [2:0] idx, logic lw);
        words_seen++;
        if (want_word.size() == 0)
        begin
            $error("digest word with none pending: %h", dw);
            mismatches++;
            return;
        end
        if (dw !== want_word[0])
        begin
            $error("digest_word expected %h actual %h", want_word[0], dw);
            mismatches++;
        end
        if (idx !== want_index[0])
        begin
            $error("word_index expected %0d actual %0d", want_index[0], idx);
            mismatches++;
        end
        if (lw !== want_last[0])
        begin
            $error("last_word expected %0b actual %0b", want_last[0], lw);
            mismatches++;
        end
        void'(want_word.pop_front());
        void'(want_index.pop_front());
        void'(want_last.pop_front());
    endfunction
endclass

module tb;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [63:0] message_word;
    logic [3:0] valid_bytes;
    logic end_of_message;
    logic out_valid;
    logic out_stall;
    logic [63:0] digest_word;
    logic [2:0] word_index;
    logic last_word;

    digest_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    int requests_sent;

    sha512_hash_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .message_word(message_word), .valid_bytes(valid_bytes),
        .end_of_message(end_of_message),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: stall at random, or hold off for a counted stretch
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_digest_word(digest_word, word_index, last_word);

    // present one request from a falling edge, after random idle cycles if send_idle_pct
    // is set; valid stays high after acceptance so the next request can follow with no gap
    task automatic send_request(logic [63:0] w, logic [3:0] nb, logic eom);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            message_word <= {$urandom, $urandom};
            valid_bytes <= 4'($urandom);
            end_of_message <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        message_word <= w;
        valid_bytes <= nb;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(w, nb, eom);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        end_of_message <= 1'b0;
        while (sb.want_word.size() != 0)
            @(negedge clk);
    endtask

    // one message of n full words plus a last word carrying nb bytes (8 when nb is above 8)
    task automatic send_message(int n, logic [3:0] nb);
        for (int i = 0; i < n; i++)
            send_request({$urandom, $urandom}, 4'($urandom), 1'b0);
        send_request({$urandom, $urandom}, nb, 1'b1);
    endtask

    task automatic random_phase(int msgs);
        int len;
        for (int m = 0; m < msgs; m++)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
            send_message(len, 4'($urandom_range(15)));
        end
    endtask

    initial
    begin
        #3000000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        message_word = '0;
        valid_bytes = '0;
        end_of_message = 1'b0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        requests_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, field extremes, padding boundaries
        send_request(64'h0, 4'd0, 1'b1);
        send_request(64'hffffffffffffffff, 4'd8, 1'b1);
        send_request(64'hffffffffffffffff, 4'd15, 1'b1);
        send_request(64'h6162638000000000, 4'd3, 1'b1);
        send_request(64'hffffffffffffffff, 4'd1, 1'b1);
        send_request(64'hffffffffffffffff, 4'd7, 1'b1);
        send_request(64'h0123456789abcdef, 4'd0, 1'b0);
        send_request(64'hfedcba9876543210, 4'd5, 1'b1);
        send_message(13, 4'd8);
        send_message(14, 4'd0);
        send_message(15, 4'd4);
        wait_drained();

        random_phase(5);
        send_idle_pct = 79;
        random_phase(5);
        send_idle_pct = 0;
        stall_pct = 79;
        random_phase(5);
        send_idle_pct = 34;
        stall_pct = 34;
        random_phase(5);
        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 400;
        random_phase(3);
        wait_drained();
        random_phase(3);

        wait_drained();
        repeat (300) @(negedge clk);
        $display("tb: %0d requests, %0d digests, %0d digest words checked",
                 requests_sent, sb.digests_seen, sb.words_seen);
        if (sb.mismatches == 0 && sb.want_word.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
